/* hw/rtl/pts_pkg.sv */
// ---------------------------------------------------------------------------
// pts_pkg: shared types and codes for the process table scheduler
// Holds entry state codes, policy codes and the configuration indexes.
// ---------------------------------------------------------------------------
package pts_pkg;

    localparam logic [1:0] ST_NOT_READY = 2'd0;
    localparam logic [1:0] ST_READY     = 2'd1;
    localparam logic [1:0] ST_RUNNING   = 2'd2;

    localparam logic [2:0] POL_FIFO     = 3'd0;
    localparam logic [2:0] POL_PRIORITY = 3'd1;
    localparam logic [2:0] POL_RANDOM   = 3'd2;
    localparam logic [2:0] POL_SJF      = 3'd3;

    localparam logic [1:0] CFG_POLICY   = 2'd0;
    localparam logic [1:0] CFG_QUANTUM  = 2'd1;
    localparam logic [1:0] CFG_PRIORITY = 2'd2;

    localparam logic ACT_WRITE = 1'b0;

    // one process table entry
    typedef struct packed {
        logic [1:0]         st;
        logic signed [7:0]  prio;
        logic [5:0]         nice;
        logic [31:0]        cpu;
        logic [15:0]        cnt;
    } entry_t;

endpackage

/* hw/rtl/pts_divider.sv */
// ---------------------------------------------------------------------------
// pts_divider: restoring remainder unit
// Computes a 15-bit dividend modulo a divisor, one quotient bit per cycle.
// ---------------------------------------------------------------------------
module pts_divider #(
    parameter int DW = 9
) (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          start,
    input  logic [14:0]   dividend,
    input  logic [DW-1:0] divisor,
    output logic          done,
    output logic [DW-1:0] remainder
);
    logic [14:0]   quo_reg, quo_next;
    logic [DW:0]   rem_reg, rem_next;
    logic [3:0]    step_reg, step_next;
    logic          busy_reg, busy_next;
    logic [DW:0]   trial;
    logic          busy_d_reg;
    logic          done_w;

    assign trial     = {rem_reg[DW-1:0], quo_reg[14]};
    assign remainder = rem_reg[DW-1:0];

    // shift in one dividend bit and subtract when it fits
    always_comb
    begin
        quo_next  = quo_reg;
        rem_next  = rem_reg;
        step_next = step_reg;
        busy_next = busy_reg;
        if (start)
        begin
            quo_next  = dividend;
            rem_next  = '0;
            step_next = '0;
            busy_next = 1'b1;
        end
        else if (busy_reg)
        begin
            quo_next = {quo_reg[13:0], 1'b0};
            if (trial >= {1'b0, divisor})
                rem_next = trial - {1'b0, divisor};
            else
                rem_next = trial;
            step_next = step_reg + 4'd1;
            if (step_reg == 4'd14)
                busy_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            step_reg <= '0;
            rem_reg  <= '0;
            quo_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            step_reg <= step_next;
            rem_reg  <= rem_next;
            quo_reg  <= quo_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            busy_d_reg <= 1'b0;
        else
            busy_d_reg <= busy_reg;
    end

    // flag the cycle after the last step
    always_comb
    begin
        if (busy_d_reg && !busy_reg)
            done_w = 1'b1;
        else
            done_w = 1'b0;
    end
    assign done = done_w;
endmodule

/* hw/rtl/process_table_scheduler.sv */
// ---------------------------------------------------------------------------
// process_table_scheduler: process table with multi-policy next-process pick
// A yield scans the table at one read per cycle; the random policy with ready
// entries makes a counting sweep, a remainder step and a picking sweep.
// The next request is taken the cycle after the result leaves. Reset clears
// control state, then a clearing pass writes every entry before the first
// request is accepted.
// ---------------------------------------------------------------------------
module process_table_scheduler #(
    parameter int NUM_PROC = 64
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               cfg_valid,
    output logic               cfg_ready,
    input  logic [1:0]         cfg_index,
    input  logic [15:0]        cfg_data,
    input  logic               in_valid,
    output logic               in_ready,
    input  logic               action,
    input  logic [5:0]         entry_index,
    input  logic               entry_state,
    input  logic signed [7:0]  entry_priority,
    input  logic [5:0]         entry_nice,
    input  logic [31:0]        entry_cpu_time,
    input  logic [14:0]        random_value,
    output logic               out_valid,
    input  logic               out_ready,
    output logic [5:0]         running_index,
    output logic               switched,
    output logic [6:0]         ready_count
);
    import pts_pkg::*;

    localparam int AW = $clog2(NUM_PROC);
    localparam int CW = $clog2(NUM_PROC + 1);

    typedef enum logic [9:0] {
        S_CLEAR = 10'b0000000001,
        S_IDLE  = 10'b0000000010,
        S_WRITE = 10'b0000000100,
        S_PREP  = 10'b0000001000,
        S_CNT   = 10'b0000010000,
        S_DIV   = 10'b0000100000,
        S_SCAN  = 10'b0001000000,
        S_FIN   = 10'b0010000000,
        S_OUT   = 10'b0100000000,
        S_RDWT  = 10'b1000000000
    } state_t;

    state_t state_reg, state_next;

    // table memory: one read and one write port, registered read
    entry_t mem [NUM_PROC];
    logic          we;
    logic [AW-1:0] waddr, raddr;
    entry_t        wdata, rdata;

    always_ff @(posedge clk)
    begin
        if (we)
            mem[waddr] <= wdata;
        rdata <= mem[raddr];
    end

    logic [2:0]         policy_reg;
    logic [15:0]        quantum_reg;
    logic signed [7:0]  uprio_reg;
    logic [AW-1:0]      cur_reg, cur_next;
    logic [AW-1:0]      ptr_reg, ptr_next;     // address being read
    logic               rv_reg, rv_next;       // rdata valid for ptr-1
    logic [AW-1:0]      rix_reg, rix_next;     // index of rdata
    logic [CW-1:0]      cnt_reg, cnt_next;
    logic [CW-1:0]      seen_reg, seen_next;
    logic [CW-1:0]      k_reg, k_next;
    logic               have_reg, have_next;
    logic [AW-1:0]      best_reg, best_next;
    entry_t             best_e_reg, best_e_next;
    logic               act_reg, act_next;
    logic [5:0]         o_idx_reg, o_idx_next;
    logic               o_sw_reg, o_sw_next;
    logic [6:0]         o_cnt_reg, o_cnt_next;
    logic               ov_reg, ov_next;
    logic [5:0]         w_idx_reg;
    entry_t             w_e_reg;
    logic [14:0]        rnd_reg;

    logic               div_start, div_done;
    logic [CW-1:0]      div_rem;

    pts_divider #(.DW(CW)) u_div (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (div_start),
        .dividend  (rnd_reg),
        .divisor   (cnt_reg),
        .done      (div_done),
        .remainder (div_rem)
    );

    assign cfg_ready     = 1'b1;
    assign in_ready      = (state_reg == S_IDLE) && !ov_reg;
    assign out_valid     = ov_reg;
    assign running_index = o_idx_reg;
    assign switched      = o_sw_reg;
    assign ready_count   = o_cnt_reg;

    // configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            policy_reg  <= POL_RANDOM;
            quantum_reg <= 16'd50;
            uprio_reg   <= 8'sd40;
        end
        else if (cfg_valid)
        begin
            case (cfg_index)
                CFG_POLICY:   policy_reg  <= cfg_data[2:0];
                CFG_QUANTUM:  quantum_reg <= cfg_data;
                CFG_PRIORITY: uprio_reg   <= cfg_data[7:0];
                default:      ;
            endcase
        end
    end

    // capture request payload
    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
        begin
            w_idx_reg <= entry_index;
            w_e_reg   <= '{st: {1'b0, entry_state}, prio: entry_priority,
                           nice: entry_nice, cpu: entry_cpu_time, cnt: 16'd0};
            rnd_reg   <= random_value;
        end
    end

    logic          lead;
    logic          last_rd;
    logic          is_rdy;
    logic [15:0]   bumped;

    assign last_rd = (ptr_reg == AW'(NUM_PROC - 1));
    assign is_rdy  = rv_reg && (rdata.st == ST_READY) && (rix_reg != '0);
    assign bumped  = (rdata.cnt == 16'hFFFF) ? rdata.cnt : rdata.cnt + 16'd1;

    // leader test for the current policy
    always_comb
    begin
        lead = 1'b0;
        if (!have_reg)
            lead = 1'b1;
        else
        begin
            case (policy_reg)
                POL_FIFO: lead = rdata.cnt > best_e_reg.cnt;
                POL_SJF:  lead = rdata.cpu < best_e_reg.cpu;
                POL_PRIORITY:
                begin
                    if (rdata.prio != best_e_reg.prio)
                        lead = rdata.prio < best_e_reg.prio;
                    else if (rdata.nice != best_e_reg.nice)
                        lead = rdata.nice < best_e_reg.nice;
                    else
                        lead = rdata.cpu < best_e_reg.cpu;
                end
                default: lead = 1'b0;
            endcase
        end
    end

    // sequencer
    always_comb
    begin
        state_next  = state_reg;
        cur_next    = cur_reg;
        ptr_next    = ptr_reg;
        rv_next     = 1'b0;
        rix_next    = ptr_reg;
        cnt_next    = cnt_reg;
        seen_next   = seen_reg;
        k_next      = k_reg;
        have_next   = have_reg;
        best_next   = best_reg;
        best_e_next = best_e_reg;
        act_next    = act_reg;
        o_idx_next  = o_idx_reg;
        o_sw_next   = o_sw_reg;
        o_cnt_next  = o_cnt_reg;
        ov_next     = ov_reg;
        we          = 1'b0;
        waddr       = ptr_reg;
        wdata       = '0;
        raddr       = ptr_reg;
        div_start   = 1'b0;

        if (ov_reg && out_ready)
            ov_next = 1'b0;

        case (state_reg)
            S_CLEAR:
            begin
                we       = 1'b1;
                waddr    = ptr_reg;
                ptr_next = ptr_reg + AW'(1);
                if (last_rd)
                    state_next = S_IDLE;
            end
            S_IDLE:
            begin
                if (in_valid && in_ready)
                begin
                    if (action == ACT_WRITE)
                        state_next = S_WRITE;
                    else
                    begin
                        raddr      = cur_reg;
                        state_next = S_PREP;
                    end
                end
            end
            S_WRITE:
            begin
                // read old entry to keep its counter when not ready
                raddr      = AW'(w_idx_reg);
                state_next = S_RDWT;
            end
            S_RDWT:
            begin
                if (9'(w_idx_reg) < 9'(NUM_PROC))
                begin
                    we    = 1'b1;
                    waddr = AW'(w_idx_reg);
                    wdata = w_e_reg;
                    if (w_e_reg.st != ST_READY)
                        wdata.cnt = rdata.cnt;
                end
                o_idx_next = 6'(cur_reg);
                o_sw_next  = 1'b0;
                o_cnt_next = '0;
                ov_next    = 1'b1;
                state_next = S_IDLE;
            end
            S_PREP:
            begin
                // put running process back to ready
                if (rdata.st == ST_RUNNING)
                begin
                    we        = 1'b1;
                    waddr     = cur_reg;
                    wdata     = rdata;
                    wdata.st  = ST_READY;
                    wdata.cnt = '0;
                end
                ptr_next   = '0;
                cnt_next   = '0;
                seen_next  = '0;
                have_next  = 1'b0;
                best_next  = '0;
                act_next   = 1'b0;
                state_next = (policy_reg == POL_RANDOM) ? S_CNT : S_SCAN;
            end
            S_CNT:
            begin
                // count ready entries, one per cycle
                raddr    = ptr_reg;
                rv_next  = !act_reg;
                rix_next = ptr_reg;
                if (!act_reg)
                    ptr_next = ptr_reg + AW'(1);
                if (last_rd)
                    act_next = 1'b1;
                if (is_rdy)
                    cnt_next = cnt_reg + CW'(1);
                if (act_reg && !rv_reg)
                begin
                    act_next = 1'b0;
                    ptr_next = '0;
                    if (cnt_reg == '0)
                        state_next = S_FIN;
                    else
                    begin
                        div_start  = 1'b1;
                        state_next = S_DIV;
                    end
                end
            end
            S_DIV:
            begin
                if (div_done)
                begin
                    k_next     = div_rem + CW'(1);
                    state_next = S_SCAN;
                end
            end
            S_SCAN:
            begin
                raddr    = ptr_reg;
                rv_next  = !act_reg;
                rix_next = ptr_reg;
                if (!act_reg)
                    ptr_next = ptr_reg + AW'(1);
                if (last_rd)
                    act_next = 1'b1;
                if (is_rdy)
                begin
                    if (policy_reg != POL_RANDOM)
                        cnt_next = cnt_reg + CW'(1);
                    case (policy_reg)
                        POL_FIFO, POL_SJF:
                        begin
                            if (lead)
                            begin
                                have_next   = 1'b1;
                                best_next   = rix_reg;
                                best_e_next = rdata;
                            end
                            else
                            begin
                                we        = 1'b1;
                                waddr     = rix_reg;
                                wdata     = rdata;
                                wdata.cnt = bumped;
                            end
                        end
                        POL_PRIORITY:
                        begin
                            if (lead)
                            begin
                                have_next   = 1'b1;
                                best_next   = rix_reg;
                                best_e_next = rdata;
                            end
                        end
                        POL_RANDOM:
                        begin
                            seen_next = seen_reg + CW'(1);
                            if (seen_reg + CW'(1) == k_reg)
                            begin
                                best_next = rix_reg;
                                have_next = 1'b1;
                            end
                            else
                            begin
                                we        = 1'b1;
                                waddr     = rix_reg;
                                wdata     = rdata;
                                wdata.cnt = bumped;
                            end
                        end
                        default: ;
                    endcase
                end
                if (act_reg && !rv_reg)
                begin
                    act_next   = 1'b0;
                    raddr      = best_reg;
                    state_next = S_FIN;
                end
            end
            S_FIN:
            begin
                // read winner entry
                raddr      = (policy_reg > POL_SJF) ? '0 : best_reg;
                state_next = S_OUT;
            end
            S_OUT:
            begin
                we        = 1'b1;
                waddr     = (policy_reg > POL_SJF) ? '0 : best_reg;
                wdata     = rdata;
                wdata.prio = uprio_reg;
                wdata.st  = ST_RUNNING;
                wdata.cnt = quantum_reg;
                cur_next  = waddr;
                o_idx_next = 6'(waddr);
                o_sw_next  = (waddr != cur_reg);
                o_cnt_next = 7'(cnt_reg);
                ov_next    = 1'b1;
                state_next = S_IDLE;
            end
            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_CLEAR;
            cur_reg   <= '0;
            ptr_reg   <= '0;
            rv_reg    <= 1'b0;
            rix_reg   <= '0;
            cnt_reg   <= '0;
            seen_reg  <= '0;
            k_reg     <= '0;
            have_reg  <= 1'b0;
            best_reg  <= '0;
            act_reg   <= 1'b0;
            ov_reg    <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            cur_reg   <= cur_next;
            ptr_reg   <= ptr_next;
            rv_reg    <= rv_next;
            rix_reg   <= rix_next;
            cnt_reg   <= cnt_next;
            seen_reg  <= seen_next;
            k_reg     <= k_next;
            have_reg  <= have_next;
            best_reg  <= best_next;
            act_reg   <= act_next;
            ov_reg    <= ov_next;
        end
    end

    always_ff @(posedge clk)
    begin
        best_e_reg <= best_e_next;
        o_idx_reg  <= o_idx_next;
        o_sw_reg   <= o_sw_next;
        o_cnt_reg  <= o_cnt_next;
    end
endmodule

/* tb/sv/tb_process_table_scheduler.sv */
// ---------------------------------------------------------------------------
// tb_process_table_scheduler: self-checking bench for the process scheduler
// Drives table writes and yields under every policy with random stalls on
// both channels, predicts each result from a local copy of the process
// table, and compares every returned result in order.
// ---------------------------------------------------------------------------
module tb_process_table_scheduler;

    import pts_pkg::*;

    localparam int NPROC      = 64;
    localparam int WATCH_MAX  = 20000;
    localparam logic [2:0] POL_IDLE = 3'd4;

    typedef struct packed {
        logic               act;
        logic [5:0]         idx;
        logic               st;
        logic signed [7:0]  prio;
        logic [5:0]         nice;
        logic [31:0]        cpu;
        logic [14:0]        rnd;
    } request_t;

    typedef struct packed {
        logic [5:0] run;
        logic       sw;
        logic [6:0] rdy;
    } pick_t;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic cfg_valid = 1'b0;
    logic cfg_ready;
    logic [1:0] cfg_index = '0;
    logic [15:0] cfg_data = '0;
    logic in_valid = 1'b0;
    logic in_ready;
    logic action = 1'b0;
    logic [5:0] entry_index = '0;
    logic entry_state = 1'b0;
    logic signed [7:0] entry_priority = '0;
    logic [5:0] entry_nice = '0;
    logic [31:0] entry_cpu_time = '0;
    logic [14:0] random_value = '0;
    logic out_valid;
    logic out_ready = 1'b0;
    logic [5:0] running_index;
    logic switched;
    logic [6:0] ready_count;

    // model state
    logic [2:0]         m_policy;
    logic [15:0]        m_quantum;
    logic signed [7:0]  m_uprio;
    entry_t             m_tab [NPROC];
    logic [5:0]         m_cur;

    request_t pending_q [$];
    pick_t    expected_q [$];
    int  errors = 0;
    int  watch = 0;
    bit  hold_sender = 1'b0;
    int  in_gap = 0;
    int  out_gap = 0;

    process_table_scheduler #(.NUM_PROC(NPROC)) u_top (.*);

    always #2 clk = ~clk;

    function automatic logic [15:0] sat_inc(logic [15:0] v);
        return (v == 16'hFFFF) ? v : v + 16'd1;
    endfunction

    // predict one result and update the model table
    function automatic pick_t schedule_step(request_t r);
        pick_t p;
        logic [5:0] nxt;
        logic [5:0] prev;
        int ready;
        int k;
        int seen;
        bit have;
        bit lead;
        nxt = '0;
        prev = m_cur;
        ready = 0;
        have = 0;
        if (r.act == ACT_WRITE) begin
            m_tab[r.idx].st = {1'b0, r.st};
            m_tab[r.idx].prio = r.prio;
            m_tab[r.idx].nice = r.nice;
            m_tab[r.idx].cpu = r.cpu;
            if (r.st)
                m_tab[r.idx].cnt = '0;
            p.run = m_cur;
            p.sw = 1'b0;
            p.rdy = '0;
            return p;
        end
        if (m_tab[m_cur].st == ST_RUNNING) begin
            m_tab[m_cur].st = ST_READY;
            m_tab[m_cur].cnt = '0;
        end
        for (int i = 1; i < NPROC; i++)
            if (m_tab[i].st == ST_READY)
                ready++;
        case (m_policy)
            POL_FIFO, POL_SJF:
                for (int i = 1; i < NPROC; i++) begin
                    if (m_tab[i].st != ST_READY)
                        continue;
                    if (!have)
                        lead = 1;
                    else if (m_policy == POL_FIFO)
                        lead = m_tab[i].cnt > m_tab[nxt].cnt;
                    else
                        lead = m_tab[i].cpu < m_tab[nxt].cpu;
                    if (lead) begin
                        nxt = i[5:0];
                        have = 1;
                    end else
                        m_tab[i].cnt = sat_inc(m_tab[i].cnt);
                end
            POL_PRIORITY:
                for (int i = 1; i < NPROC; i++) begin
                    if (m_tab[i].st != ST_READY)
                        continue;
                    if (!have)
                        lead = 1;
                    else if (m_tab[i].prio != m_tab[nxt].prio)
                        lead = m_tab[i].prio < m_tab[nxt].prio;
                    else if (m_tab[i].nice != m_tab[nxt].nice)
                        lead = m_tab[i].nice < m_tab[nxt].nice;
                    else
                        lead = m_tab[i].cpu < m_tab[nxt].cpu;
                    if (lead) begin
                        nxt = i[5:0];
                        have = 1;
                    end
                end
            POL_RANDOM:
                if (ready != 0) begin
                    k = (int'(r.rnd) % ready) + 1;
                    seen = 0;
                    for (int i = 1; i < NPROC; i++) begin
                        if (m_tab[i].st != ST_READY)
                            continue;
                        seen++;
                        if (seen == k)
                            nxt = i[5:0];
                        else
                            m_tab[i].cnt = sat_inc(m_tab[i].cnt);
                    end
                end
            default: ;
        endcase
        m_tab[nxt].prio = m_uprio;
        m_tab[nxt].st = ST_RUNNING;
        m_tab[nxt].cnt = m_quantum;
        m_cur = nxt;
        p.run = nxt;
        p.sw = (nxt != prev);
        p.rdy = ready[6:0];
        return p;
    endfunction

    function automatic request_t rand_request(bit yield_bias);
        request_t r;
        r.act = yield_bias ? ($urandom_range(0, 2) != 0) : 1'($urandom_range(0, 1));
        r.idx = 6'($urandom_range(0, 63));
        r.st = ($urandom_range(0, 3) != 0);
        r.prio = 8'($urandom_range(0, 255));
        if ($urandom_range(0, 3) == 0)
            r.prio = 8'(int'($urandom_range(0, 3)) - 2);
        r.nice = $urandom_range(0, 1) ? 6'($urandom_range(0, 39))
                                      : 6'($urandom_range(0, 63));
        r.cpu = $urandom_range(0, 1) ? $urandom() : $urandom_range(0, 7);
        r.rnd = 15'($urandom_range(0, 32767));
        return r;
    endfunction

    // apply one register write on the config channel
    task automatic write_reg(logic [1:0] idx, logic [15:0] val);
        @(posedge clk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data <= val;
        do @(posedge clk); while (!cfg_ready);
        cfg_valid <= 1'b0;
        case (idx)
            CFG_POLICY:   m_policy = val[2:0];
            CFG_QUANTUM:  m_quantum = val;
            CFG_PRIORITY: m_uprio = val[7:0];
            default: ;
        endcase
    endtask

    // wait until the queue is drained and the block is quiet
    task automatic drain();
        wait (pending_q.size() == 0 && expected_q.size() == 0 && !in_valid);
        repeat (200) @(posedge clk);
    endtask

    // driver: present queued requests with random gaps
    always @(posedge clk) begin
        if (in_valid && in_ready) begin
            expected_q.push_back(schedule_step(pending_q.pop_front()));
        end
        if (!in_valid || in_ready) begin
            if (in_valid && in_ready)
                in_gap = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 18) : 0;
            if (in_gap > 0 || hold_sender || pending_q.size() == 0
                    || (in_valid && in_ready && pending_q.size() == 0)) begin
                if (in_gap > 0)
                    in_gap--;
                in_valid <= 1'b0;
            end else begin
                in_valid <= 1'b1;
                action <= pending_q[0].act;
                entry_index <= pending_q[0].idx;
                entry_state <= pending_q[0].st;
                entry_priority <= pending_q[0].prio;
                entry_nice <= pending_q[0].nice;
                entry_cpu_time <= pending_q[0].cpu;
                random_value <= pending_q[0].rnd;
            end
        end
    end

    // monitor: check results, apply output stalls
    always @(posedge clk) begin
        pick_t e;
        if (out_valid && out_ready) begin
            if (expected_q.size() == 0) begin
                $error("result with nothing expected: run=%0d", running_index);
                errors++;
            end else begin
                e = expected_q.pop_front();
                if (running_index !== e.run) begin
                    $error("running_index exp %0d got %0d", e.run, running_index);
                    errors++;
                end
                if (switched !== e.sw) begin
                    $error("switched exp %0d got %0d", e.sw, switched);
                    errors++;
                end
                if (ready_count !== e.rdy) begin
                    $error("ready_count exp %0d got %0d", e.rdy, ready_count);
                    errors++;
                end
            end
            out_gap = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 18) : 0;
        end
        if (out_gap > 0) begin
            out_gap--;
            out_ready <= 1'b0;
        end else
            out_ready <= 1'b1;
    end

    // watchdog on accepted traffic
    always @(posedge clk) begin
        if ((in_valid && in_ready) || (out_valid && out_ready) || (cfg_valid && cfg_ready)
                || !rst_n)
            watch <= 0;
        else
            watch <= watch + 1;
        if (watch >= WATCH_MAX) begin
            $display("Mismatches found");
            $finish;
        end
    end

    initial begin
        request_t r;
        logic [2:0] pols [6];
        m_policy = POL_RANDOM;
        m_quantum = 16'd50;
        m_uprio = 8'sd40;
        m_cur = '0;
        for (int i = 0; i < NPROC; i++)
            m_tab[i] = '0;
        pols = '{POL_FIFO, POL_PRIORITY, POL_RANDOM, POL_SJF, POL_IDLE, 3'd7};
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;

        // directed: yield on an empty table, extremes, each policy
        r = '0; r.act = 1'b1; r.rnd = 15'h7FFF;
        pending_q.push_back(r);
        for (int i = 0; i < 6; i++) begin
            r = '0;
            r.idx = (i == 0) ? 6'd63 : i[5:0];
            r.st = 1'b1;
            r.prio = (i % 2) ? 8'sh7F : 8'sh80;
            r.nice = (i == 1) ? 6'd63 : 6'd0;
            r.cpu = (i == 2) ? 32'hFFFFFFFF : i;
            pending_q.push_back(r);
        end
        r = '0; r.idx = 6'd5; r.st = 1'b0;
        pending_q.push_back(r);
        r = '0; r.act = 1'b1; r.rnd = 15'd3;
        pending_q.push_back(r);
        drain();
        write_reg(CFG_QUANTUM, 16'hFFFF);
        write_reg(CFG_PRIORITY, 16'h0080);
        for (int p = 0; p < 6; p++) begin
            write_reg(CFG_POLICY, {13'd0, pols[p]});
            for (int j = 0; j < 3; j++) begin
                r = '0; r.act = 1'b1; r.rnd = j ? 15'd0 : 15'h7FFF;
                pending_q.push_back(r);
            end
            drain();
            // write to the running entry
            r = '0; r.idx = m_cur; r.st = 1'b1; r.cpu = 32'd9;
            pending_q.push_back(r);
            drain();
        end

        // random phases across settings; sender hold-off in one of them
        for (int ph = 0; ph < 30; ph++) begin
            write_reg(CFG_POLICY, {13'd0, pols[ph % 6]});
            write_reg(CFG_QUANTUM, (ph % 3 == 0) ? 16'd0 : 16'($urandom_range(0, 65535)));
            write_reg(CFG_PRIORITY, (ph % 4 == 0) ? 16'h007F : 16'($urandom_range(0, 255)));
            for (int n = 0; n < 60; n++)
                pending_q.push_back(rand_request(ph % 2 == 0));
            if (ph == 3) begin
                wait (pending_q.size() <= 30);
                hold_sender = 1'b1;
                wait (expected_q.size() == 0 && !in_valid);
                hold_sender = 1'b0;
            end
            drain();
        end

        if (errors == 0)
            $display("No mismatches found");
        else
            $display("Mismatches found");
        $finish;
    end

endmodule
